@@ rtl/core/rrtl_pkg.sv @@
package rrtl_pkg;

    localparam int SMP_W  = 16;
    localparam int DLY_W  = 11;
    localparam int GAIN_W = 8;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // The crossfade length is a power of two, so its divisions are shifts.
    localparam int XFADE_LEN = 32;
    localparam int XF_SHIFT  = $clog2(XFADE_LEN);
    localparam int FC_W      = $clog2(XFADE_LEN + 1);

    localparam int TAPX_W = SMP_W + 1;
    localparam int SUM_W  = SMP_W + 1;
    localparam int WET_W  = SMP_W + 2;
    localparam int SAT_W  = SMP_W + 4;

    localparam int WET_MUL     = 11;
    localparam int WET_SHIFT   = 6;
    localparam int DIV6_MUL    = 174763;
    localparam int DIV6_MUL_W  = 18;
    localparam int DIV6_SHIFT  = 20;

    localparam logic [2:0] REG_FIRST_DELAY  = 3'd0;
    localparam logic [2:0] REG_SECOND_DELAY = 3'd1;
    localparam logic [2:0] REG_FEEDBACK     = 3'd2;
    localparam logic [2:0] REG_LOWPASS      = 3'd3;
    localparam logic [2:0] REG_GAIN_MODE    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAP,
        ST_FADE,
        ST_XMUL,
        ST_XSUM,
        ST_FBMUL,
        ST_WRITE,
        ST_SUM,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                     en;
        t_state                   state;
        logic                     silent;
        logic signed [SMP_W-1:0]  vlr;
        logic [GAIN_W-1:0]        gain;
        logic                     lowpass;
        logic                     clr;
    } t_line_ctl;

    typedef struct packed {
        logic activate;
        logic change;
        logic stop;
    } t_line_cfg;

    function automatic logic signed [SMP_W-1:0] clip16(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        logic signed [SMP_W-1:0] res;
        hi = SAT_W'(32767);
        lo = -SAT_W'(32768);
        if (v > hi) begin
            res = 16'sh7FFF;
        end else if (v < lo) begin
            res = 16'sh8000;
        end else begin
            res = v[SMP_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/rrtl_line.sv @@
module rrtl_line #(
    parameter int LINE_DEPTH = 2048,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rrtl_pkg::t_line_ctl                   i_ctl,
    input  rrtl_pkg::t_line_cfg                   i_cfg,
    input  logic [AW-1:0]                         i_cfg_ptr,
    input  logic [AW-1:0]                         i_wp,
    input  logic [AW-1:0]                         i_clr_addr,
    output logic signed [rrtl_pkg::SMP_W-1:0]     o_valt
);

    localparam int SW    = rrtl_pkg::SMP_W;
    localparam int FCW   = rrtl_pkg::FC_W;
    localparam int TW    = rrtl_pkg::TAPX_W;
    localparam int PW    = SW + FCW + 1;
    localparam int PRD_W = rrtl_pkg::GAIN_W + 1 + TW;
    localparam int SATW  = rrtl_pkg::SAT_W;
    localparam logic signed [PW-1:0] XF_BIAS = PW'(rrtl_pkg::XFADE_LEN - 1);

    logic signed [SW-1:0] mem [LINE_DEPTH];

    logic [AW-1:0]         r_rp;
    logic [AW-1:0]         r_fp;
    logic [FCW-1:0]        r_fc;
    logic signed [SW-1:0]  r_hold;
    logic signed [SW-1:0]  r_rdata;
    logic signed [SW-1:0]  r_tap;
    logic signed [PW-1:0]  r_p1;
    logic signed [PW-1:0]  r_p2;
    logic signed [TW-1:0]  r_tapx;
    logic signed [PRD_W-1:0] r_prod;
    logic signed [SW-1:0]  r_valt;

    logic [AW-1:0]         raddr;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic signed [SW-1:0]  wdata;
    logic [AW-1:0]         rp_inc;
    logic [AW-1:0]         fp_inc;
    logic [FCW-1:0]        fc_rem;
    logic signed [PW-1:0]  p1_adj;
    logic signed [PW-1:0]  p2_adj;
    logic signed [PW-1:0]  p1_sh;
    logic signed [PW-1:0]  p2_sh;
    logic signed [PRD_W-9:0] fb_sh;
    logic signed [SATW-1:0] fb_sum;
    logic signed [SW-1:0]  val;
    logic signed [SW:0]    lp_sum;
    logic signed [SW-1:0]  valt;
    logic                  idle;
    logic                  wr_step;

    always_comb begin
        wr_step = i_ctl.en && (i_ctl.state == rrtl_pkg::ST_WRITE);
        raddr   = (i_ctl.state == rrtl_pkg::ST_TAP) ? r_rp : r_fp;
        rp_inc  = (r_rp == AW'(LINE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        fp_inc  = (r_fp == AW'(LINE_DEPTH - 1)) ? '0 : r_fp + 1'b1;
        fc_rem  = FCW'(rrtl_pkg::XFADE_LEN) - r_fc;

        // Division toward zero: bias negative products before the shift.
        p1_adj = r_p1[PW-1] ? r_p1 + XF_BIAS : r_p1;
        p2_adj = r_p2[PW-1] ? r_p2 + XF_BIAS : r_p2;
        p1_sh  = p1_adj >>> rrtl_pkg::XF_SHIFT;
        p2_sh  = p2_adj >>> rrtl_pkg::XF_SHIFT;

        fb_sh  = r_prod[PRD_W-1:8];
        fb_sum = SATW'(i_ctl.vlr) + SATW'(fb_sh);
        val    = rrtl_pkg::clip16(fb_sum);
        lp_sum = (SW+1)'(r_hold) + (SW+1)'(val);
        idle   = (r_fc == '0) && (r_tap == '0) && i_ctl.silent;

        if (idle) begin
            valt = '0;
        end else if (i_ctl.lowpass) begin
            valt = lp_sum[SW:1];
        end else begin
            valt = val;
        end

        we    = i_ctl.clr || wr_step;
        waddr = i_ctl.clr ? i_clr_addr : i_wp;
        wdata = i_ctl.clr ? '0 : valt;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_fp   <= '0;
            r_fc   <= '0;
            r_hold <= '0;
        end else begin
            priority if (i_cfg.activate) begin
                r_rp   <= i_cfg_ptr;
                r_fc   <= '0;
                r_hold <= '0;
            end else if (i_cfg.change) begin
                r_fp <= i_cfg_ptr;
                r_fc <= FCW'(rrtl_pkg::XFADE_LEN);
            end else if (i_cfg.stop) begin
                r_fc <= '0;
            end else begin
                if (wr_step) begin
                    if (!idle && (r_fc == FCW'(1))) begin
                        // The last faded sample hands the read side over to the new tap.
                        r_rp <= fp_inc;
                    end else begin
                        r_rp <= rp_inc;
                    end
                    if (idle) begin
                        r_hold <= '0;
                    end else begin
                        if (i_ctl.lowpass) begin
                            r_hold <= val;
                        end
                        if (r_fc != '0) begin
                            r_fp <= fp_inc;
                            r_fc <= r_fc - 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.state == rrtl_pkg::ST_FADE) begin
            r_tap <= r_rdata;
        end
        if (i_ctl.state == rrtl_pkg::ST_XMUL) begin
            r_p1 <= r_tap * $signed({1'b0, r_fc});
            r_p2 <= r_rdata * $signed({1'b0, fc_rem});
        end
        if (i_ctl.state == rrtl_pkg::ST_XSUM) begin
            r_tapx <= (r_fc != '0) ? TW'(p1_sh) + TW'(p2_sh) : TW'(r_tap);
        end
        if (i_ctl.state == rrtl_pkg::ST_FBMUL) begin
            r_prod <= $signed({1'b0, i_ctl.gain}) * r_tapx;
        end
        if (i_ctl.state == rrtl_pkg::ST_WRITE) begin
            r_valt <= valt;
        end
    end

    assign o_valt = r_valt;

endmodule

@@ rtl/core/rrtl_mix.sv @@
module rrtl_mix (
    input  logic                                  i_clk,
    input  rrtl_pkg::t_state                      i_state,
    input  logic                                  i_line2_en,
    input  logic                                  i_gain_mode,
    input  logic signed [rrtl_pkg::SMP_W-1:0]     i_valt0,
    input  logic signed [rrtl_pkg::SMP_W-1:0]     i_valt1,
    output logic signed [rrtl_pkg::WET_W-1:0]     o_wet
);

    localparam int SUMW = rrtl_pkg::SUM_W;
    localparam int M11W = SUMW + 4;
    localparam int D6W  = SUMW + rrtl_pkg::DIV6_MUL_W;
    localparam int QW   = D6W - rrtl_pkg::DIV6_SHIFT;
    localparam int WW   = rrtl_pkg::WET_W;

    logic signed [SUMW-1:0] r_sum;
    logic signed [WW-1:0]   r_wet;

    logic                   neg;
    logic [SUMW-1:0]        mag;
    logic [D6W-1:0]         d6_prod;
    logic [QW-1:0]          q6;
    logic signed [QW:0]     d6;
    logic signed [M11W-1:0] m11;
    logic signed [M11W-rrtl_pkg::WET_SHIFT-1:0] sh11;

    always_comb begin
        // Divide by six as a reciprocal multiply on the magnitude; exact for this range.
        neg     = r_sum[SUMW-1];
        mag     = neg ? SUMW'(-r_sum) : SUMW'(r_sum);
        d6_prod = D6W'(mag) * D6W'(rrtl_pkg::DIV6_MUL);
        q6      = d6_prod[D6W-1:rrtl_pkg::DIV6_SHIFT];
        d6      = neg ? -$signed({1'b0, q6}) : $signed({1'b0, q6});
        m11     = M11W'(r_sum) * M11W'(rrtl_pkg::WET_MUL);
        sh11    = m11[M11W-1:rrtl_pkg::WET_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_state == rrtl_pkg::ST_SUM) begin
            r_sum <= SUMW'(i_valt0) + (i_line2_en ? SUMW'(i_valt1) : '0);
        end
        if (i_state == rrtl_pkg::ST_SCALE) begin
            r_wet <= i_gain_mode ? WW'(d6) : WW'(sh11);
        end
    end

    assign o_wet = r_wet;

endmodule

@@ rtl/core/room_reverb_two_line.sv @@
// Two-line feedback delay reverb for a stereo 16-bit stream. Each accepted sample pair is
// mixed to mono, run through two ring-buffer delay lines with feedback, optional two-tap
// lowpass and a linear crossfade when a delay changes, and the scaled wet sum is added back
// to both channels with clipping. The block works on one transaction at a time: it takes
// no new sample pair until the last one's result is loaded into the output register, which
// waits while the output is stalled. With first_delay nonzero the result passes the chain
// of two registered memory reads (tap, then fade), the registered crossfade and feedback
// multiplies, the write back and the wet sum and scaling stages. With first_delay at zero
// the block is in bypass and the sample pair goes straight to the output register. A finished
// result sits in the output register while the next input is taken. After reset both lines'
// memories, and after any write that turns a delay line on from zero that line's memory,
// are swept to zero, during which the input is stalled; register writes are taken at all
// times but must only be issued while no transaction is in flight.
module room_reverb_two_line #(
    parameter int LINE_DEPTH = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [rrtl_pkg::SMP_W-1:0]     i_left_in,
    input  logic signed [rrtl_pkg::SMP_W-1:0]     i_right_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [rrtl_pkg::SMP_W-1:0]     o_left_out,
    output logic signed [rrtl_pkg::SMP_W-1:0]     o_right_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rrtl_pkg::APB_AW-1:0]           paddr,
    input  logic [rrtl_pkg::APB_DW-1:0]           pwdata,
    output logic [rrtl_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);

    localparam int AW   = $clog2(LINE_DEPTH);
    localparam int DW   = rrtl_pkg::DLY_W;
    localparam int SW   = rrtl_pkg::SMP_W;
    localparam int SATW = rrtl_pkg::SAT_W;
    localparam int CW   = ((AW > DW) ? AW : DW) + 2;

    // Configuration registers.
    logic [DW-1:0]              r_first_delay;
    logic [DW-1:0]              r_second_delay;
    logic [rrtl_pkg::GAIN_W-1:0] r_gain;
    logic                       r_lowpass;
    logic                       r_gain_mode;

    // Sequencer, shared write pointer and memory clearing sweep.
    rrtl_pkg::t_state           r_state;
    rrtl_pkg::t_state           n_state;
    logic [AW-1:0]              r_wp;
    logic                       r_clr_busy;
    logic [1:0]                 r_clr_pend;
    logic [AW-1:0]              r_clr_cnt;

    // Captured input sample pair and its mono mid value.
    logic signed [SW-1:0]       r_left;
    logic signed [SW-1:0]       r_right;
    logic signed [SW-1:0]       r_vlr;
    logic                       r_silent;

    // Output register.
    logic                       r_out_valid;
    logic signed [SW-1:0]       r_left_out;
    logic signed [SW-1:0]       r_right_out;

    logic                       accept;
    logic                       out_load;
    logic                       bypass;
    logic [AW-1:0]              wp_inc;
    logic signed [SW:0]         lr_sum;

    logic                       cfg_wr;
    logic [2:0]                 cfg_idx;
    logic [DW-1:0]              cfg_nv;
    logic [CW-1:0]              eff;
    logic [CW-1:0]              behind;
    logic [AW-1:0]              cfg_ptr;
    rrtl_pkg::t_line_cfg        cfg0;
    rrtl_pkg::t_line_cfg        cfg1;
    rrtl_pkg::t_line_ctl        ctl0;
    rrtl_pkg::t_line_ctl        ctl1;

    logic signed [SW-1:0]       valt0;
    logic signed [SW-1:0]       valt1;
    logic signed [rrtl_pkg::WET_W-1:0] wet;
    logic signed [rrtl_pkg::WET_W-1:0] wet_use;

    // A delay write is classified against the current value of its register. Turning a line
    // on resets its read pointer and clears its memory; changing the delay of a running line
    // starts a crossfade toward a new tap; writing zero stops any crossfade.
    always_comb begin
        cfg_wr  = psel && penable && pwrite;
        cfg_idx = paddr[4:2];
        cfg_nv  = pwdata[DW-1:0];

        cfg0.activate = cfg_wr && (cfg_idx == rrtl_pkg::REG_FIRST_DELAY) &&
                        (cfg_nv != '0) && (r_first_delay == '0);
        cfg0.change   = cfg_wr && (cfg_idx == rrtl_pkg::REG_FIRST_DELAY) &&
                        (cfg_nv != '0) && (r_first_delay != '0) && (cfg_nv != r_first_delay);
        cfg0.stop     = cfg_wr && (cfg_idx == rrtl_pkg::REG_FIRST_DELAY) &&
                        (cfg_nv == '0) && (r_first_delay != '0);
        cfg1.activate = cfg_wr && (cfg_idx == rrtl_pkg::REG_SECOND_DELAY) &&
                        (cfg_nv != '0) && (r_second_delay == '0);
        cfg1.change   = cfg_wr && (cfg_idx == rrtl_pkg::REG_SECOND_DELAY) &&
                        (cfg_nv != '0) && (r_second_delay != '0) && (cfg_nv != r_second_delay);
        cfg1.stop     = cfg_wr && (cfg_idx == rrtl_pkg::REG_SECOND_DELAY) &&
                        (cfg_nv == '0) && (r_second_delay != '0);

        // New tap position: the write pointer minus the delay, with the delay saturated to
        // one less than the line depth.
        eff     = (CW'(cfg_nv) >= CW'(LINE_DEPTH)) ? CW'(LINE_DEPTH - 1) : CW'(cfg_nv);
        behind  = CW'(r_wp) + CW'(LINE_DEPTH) - eff;
        cfg_ptr = (behind >= CW'(LINE_DEPTH)) ? AW'(behind - CW'(LINE_DEPTH)) : AW'(behind);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay  <= '0;
            r_second_delay <= '0;
            r_gain         <= '0;
            r_lowpass      <= 1'b0;
            r_gain_mode    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rrtl_pkg::REG_FIRST_DELAY:  r_first_delay  <= cfg_nv;
                rrtl_pkg::REG_SECOND_DELAY: r_second_delay <= cfg_nv;
                rrtl_pkg::REG_FEEDBACK:     r_gain         <= pwdata[rrtl_pkg::GAIN_W-1:0];
                rrtl_pkg::REG_LOWPASS:      r_lowpass      <= pwdata[0];
                rrtl_pkg::REG_GAIN_MODE:    r_gain_mode    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rrtl_pkg::REG_FIRST_DELAY:  prdata = rrtl_pkg::APB_DW'(r_first_delay);
            rrtl_pkg::REG_SECOND_DELAY: prdata = rrtl_pkg::APB_DW'(r_second_delay);
            rrtl_pkg::REG_FEEDBACK:     prdata = rrtl_pkg::APB_DW'(r_gain);
            rrtl_pkg::REG_LOWPASS:      prdata = rrtl_pkg::APB_DW'(r_lowpass);
            rrtl_pkg::REG_GAIN_MODE:    prdata = rrtl_pkg::APB_DW'(r_gain_mode);
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Clearing sweep. Reset marks both lines; an activation marks its line and restarts the
    // sweep, so a line is always fully cleared before the next sample is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_pend <= 2'b11;
            r_clr_cnt  <= '0;
        end else if (cfg0.activate || cfg1.activate) begin
            r_clr_busy <= 1'b1;
            r_clr_pend <= r_clr_pend | {cfg1.activate, cfg0.activate};
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_cnt == AW'(LINE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
                r_clr_pend <= '0;
            end else begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // Sequencer. Both lines run in lockstep: tap read, fade read, crossfade multiply,
    // crossfade sum, feedback multiply, then write back. The memory accesses of one sample
    // never overlap those of the next, so no forwarding is needed.
    always_comb begin
        bypass     = (r_first_delay == '0);
        o_in_stall = (r_state != rrtl_pkg::ST_IDLE) || r_clr_busy;
        accept     = i_in_valid && !o_in_stall;
        out_load   = (r_state == rrtl_pkg::ST_OUT) && (!r_out_valid || !i_out_stall);
        n_state    = r_state;
        unique case (r_state)
            rrtl_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = bypass ? rrtl_pkg::ST_OUT : rrtl_pkg::ST_TAP;
                end
            end
            rrtl_pkg::ST_TAP:   n_state = rrtl_pkg::ST_FADE;
            rrtl_pkg::ST_FADE:  n_state = rrtl_pkg::ST_XMUL;
            rrtl_pkg::ST_XMUL:  n_state = rrtl_pkg::ST_XSUM;
            rrtl_pkg::ST_XSUM:  n_state = rrtl_pkg::ST_FBMUL;
            rrtl_pkg::ST_FBMUL: n_state = rrtl_pkg::ST_WRITE;
            rrtl_pkg::ST_WRITE: n_state = rrtl_pkg::ST_SUM;
            rrtl_pkg::ST_SUM:   n_state = rrtl_pkg::ST_SCALE;
            rrtl_pkg::ST_SCALE: n_state = rrtl_pkg::ST_OUT;
            rrtl_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = rrtl_pkg::ST_IDLE;
                end
            end
            default: n_state = rrtl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrtl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign wp_inc = (r_wp == AW'(LINE_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (r_state == rrtl_pkg::ST_WRITE) begin
            r_wp <= wp_inc;
        end
    end

    assign lr_sum = (SW+1)'(i_left_in) + (SW+1)'(i_right_in);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left   <= i_left_in;
            r_right  <= i_right_in;
            r_vlr    <= lr_sum[SW:1];
            r_silent <= (i_left_in == '0) && (i_right_in == '0);
        end
    end

    always_comb begin
        ctl0.en      = !bypass;
        ctl0.state   = r_state;
        ctl0.silent  = r_silent;
        ctl0.vlr     = r_vlr;
        ctl0.gain    = r_gain;
        ctl0.lowpass = r_lowpass;
        ctl0.clr     = r_clr_busy && r_clr_pend[0];

        ctl1         = ctl0;
        ctl1.en      = (r_second_delay != '0);
        ctl1.clr     = r_clr_busy && r_clr_pend[1];
    end

    rrtl_line #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl0),
        .i_cfg      (cfg0),
        .i_cfg_ptr  (cfg_ptr),
        .i_wp       (r_wp),
        .i_clr_addr (r_clr_cnt),
        .o_valt     (valt0)
    );

    rrtl_line #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl1),
        .i_cfg      (cfg1),
        .i_cfg_ptr  (cfg_ptr),
        .i_wp       (r_wp),
        .i_clr_addr (r_clr_cnt),
        .o_valt     (valt1)
    );

    rrtl_mix u_mix (
        .i_clk       (i_clk),
        .i_state     (r_state),
        .i_line2_en  (ctl1.en),
        .i_gain_mode (r_gain_mode),
        .i_valt0     (valt0),
        .i_valt1     (valt1),
        .o_wet       (wet)
    );

    // In bypass the wet path is not run and the dry sample passes unchanged.
    assign wet_use = bypass ? '0 : wet;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_left_out  <= rrtl_pkg::clip16(SATW'(r_left) + SATW'(wet_use));
            r_right_out <= rrtl_pkg::clip16(SATW'(r_right) + SATW'(wet_use));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

@@ rtl/core/rrtl_checker.sv @@
module rrtl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [rrtl_pkg::SMP_W-1:0] o_left_out,
    input logic signed [rrtl_pkg::SMP_W-1:0] o_right_out
);

    // The memory sweep after reset holds off input.
    a_stall_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input taken during the clearing sweep after reset");

    // Only one transaction is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a transaction is still in work");

    // A new result is only produced from the work phase, never straight from idle.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a transaction in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_left_out) && $stable(o_right_out)))
        else $error("stalled result changed or dropped");

endmodule

bind room_reverb_two_line rrtl_checker u_rrtl_checker (.*);
